FILE: src/hsv_integral_histogram_macros.svh
// assertion macros for the hsv integral histogram block
// used by the top level; expects aclk and aresetn in the including scope
`ifndef HSV_INTEGRAL_HISTOGRAM_MACROS_SVH
`define HSV_INTEGRAL_HISTOGRAM_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define HSVIH_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// expression must never be true out of reset
`define HSVIH_NEVER(name, expr, msg) `HSVIH_ASSERT(name, !(expr), msg)
`else
`define HSVIH_ASSERT(name, prop, msg)
`define HSVIH_NEVER(name, expr, msg)
`endif
`endif

FILE: src/hsvih_pkg.sv
// shared types and constants of the hsv integral histogram block
// no dependencies; imported by the config, controller, datapath and top modules
package hsvih_pkg;

    // fixed field widths
    localparam int SAMPLE_W     = 8;
    localparam int EDGE_W       = 9;
    localparam int EDGES_PER_REG = 7;
    localparam int EDGE_REGS    = 3;
    localparam int EDGE_SLOTS   = EDGES_PER_REG * EDGE_REGS;
    localparam int EDGE_BUS_W   = 64 * EDGE_REGS;
    localparam int CH_W         = 6;
    localparam int BIN_W        = 5;
    localparam int COUNT_W      = 21;
    localparam int ROWSUM_W     = 11;
    localparam int SIZE_CFG_W   = 11;
    localparam int SIZE_W       = 13;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_EDGES_A    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_EDGES_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_EDGES_C    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SATVAL_EDGES_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SATVAL_EDGES_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SATVAL_EDGES_C = 3'd7;

    // which sample a channel bins
    typedef enum logic [2:0] {
        KIND_HUE = 3'b001,
        KIND_SAT = 3'b010,
        KIND_VAL = 3'b100
    } kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              issue;
        logic [CH_W-1:0]   ch;
        kind_t             kind;
        logic [BIN_W-1:0]  bin;
        logic              last;
        logic              first_row;
        logic              first_col;
    } cmd_t;

    // edge n of a packed edge bus, zero past the last slot
    function automatic logic [EDGE_W-1:0] edge_at(input logic [EDGE_BUS_W-1:0] regs,
                                                  input logic [BIN_W-1:0] n);
        logic [EDGE_W-1:0] result;
        result = '0;
        for (int i = 0; i < EDGE_SLOTS; i++) begin
            if (n == BIN_W'(i)) begin
                result = regs[(i / EDGES_PER_REG) * 64 + EDGE_W * (i % EDGES_PER_REG) +: EDGE_W];
            end
        end
        return result;
    endfunction

endpackage

FILE: src/hsvih_cfg.sv
// configuration register file: image size and packed bin edges
// depends on hsvih_pkg
module hsvih_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsvih_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hsvih_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [hsvih_pkg::SIZE_CFG_W-1:0]  image_width,
    output logic [hsvih_pkg::SIZE_CFG_W-1:0]  image_height,
    output logic [hsvih_pkg::EDGE_BUS_W-1:0]  hue_edges,
    output logic [hsvih_pkg::EDGE_BUS_W-1:0]  satval_edges
);
    import hsvih_pkg::*;

    logic [SIZE_CFG_W-1:0] width_reg;
    logic [SIZE_CFG_W-1:0] height_reg;
    logic [CFG_DATA_W-1:0] hue_a_reg, hue_b_reg, hue_c_reg;
    logic [CFG_DATA_W-1:0] sv_a_reg, sv_b_reg, sv_c_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_CFG_W'(1024);
            height_reg <= SIZE_CFG_W'(1024);
            hue_a_reg  <= '0;
            hue_b_reg  <= '0;
            hue_c_reg  <= '0;
            sv_a_reg   <= '0;
            sv_b_reg   <= '0;
            sv_c_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:    width_reg  <= cfg_data[SIZE_CFG_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg <= cfg_data[SIZE_CFG_W-1:0];
                REG_HUE_EDGES_A:    hue_a_reg  <= cfg_data;
                REG_HUE_EDGES_B:    hue_b_reg  <= cfg_data;
                REG_HUE_EDGES_C:    hue_c_reg  <= cfg_data;
                REG_SATVAL_EDGES_A: sv_a_reg   <= cfg_data;
                REG_SATVAL_EDGES_B: sv_b_reg   <= cfg_data;
                REG_SATVAL_EDGES_C: sv_c_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign hue_edges    = {hue_c_reg, hue_b_reg, hue_a_reg};
    assign satval_edges = {sv_c_reg, sv_b_reg, sv_a_reg};

endmodule

FILE: src/hsvih_ctrl.sv
// controller: pixel handshake, channel sequencing and raster position
// depends on hsvih_pkg
module hsvih_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int HUE_BINS   = 17,
    parameter int SV_BINS    = 16,
    parameter int XW         = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              stall,
    input  logic [hsvih_pkg::SIZE_CFG_W-1:0]  image_width,
    input  logic [hsvih_pkg::SIZE_CFG_W-1:0]  image_height,
    output hsvih_pkg::cmd_t                   cmd,
    output logic [XW-1:0]                     col
);
    import hsvih_pkg::*;

    localparam int NUM_CH = HUE_BINS + 2 * SV_BINS;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    kind_t             kind_reg, kind_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic [XW-1:0]     col_reg, col_next;
    logic [YW-1:0]     row_reg, row_next;

    logic              issue;
    logic              last;
    logic [SIZE_W-1:0] w_ext, h_ext, w_eff, h_eff, col_inc, row_inc;

    // effective frame size: zero acts as one, clamp to the maximum
    always_comb begin
        w_ext = SIZE_W'(image_width);
        h_ext = SIZE_W'(image_height);
        if (w_ext == '0) begin
            w_eff = SIZE_W'(1);
        end else if (w_ext > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = SIZE_W'(1);
        end else if (h_ext > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_RUN) && !stall;
    assign last     = (ch_reg == CH_W'(NUM_CH - 1));
    assign col_inc  = SIZE_W'(col_reg) + SIZE_W'(1);
    assign row_inc  = SIZE_W'(row_reg) + SIZE_W'(1);

    // channel sequencing and position update
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        kind_next  = kind_reg;
        bin_next   = bin_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (last) begin
                        state_next = ST_IDLE;
                        ch_next    = '0;
                        kind_next  = KIND_HUE;
                        bin_next   = '0;
                        if (col_inc >= w_eff) begin
                            col_next = '0;
                            if (row_inc >= h_eff) begin
                                row_next = '0;
                            end else begin
                                row_next = row_inc[YW-1:0];
                            end
                        end else begin
                            col_next = col_inc[XW-1:0];
                        end
                    end else begin
                        ch_next  = ch_reg + CH_W'(1);
                        bin_next = bin_reg + BIN_W'(1);
                        if (kind_reg == KIND_HUE && bin_reg == BIN_W'(HUE_BINS - 1)) begin
                            kind_next = KIND_SAT;
                            bin_next  = '0;
                        end else if (kind_reg == KIND_SAT &&
                                     bin_reg == BIN_W'(SV_BINS - 1)) begin
                            kind_next = KIND_VAL;
                            bin_next  = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= '0;
            kind_reg  <= KIND_HUE;
            bin_reg   <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            kind_reg  <= kind_next;
            bin_reg   <= bin_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // commands to the datapath
    always_comb begin
        cmd.load      = s_tvalid && s_tready;
        cmd.issue     = issue;
        cmd.ch        = ch_reg;
        cmd.kind      = kind_reg;
        cmd.bin       = bin_reg;
        cmd.last      = last;
        cmd.first_row = (row_reg == '0);
        cmd.first_col = (col_reg == '0);
    end

    assign col = col_reg;

endmodule

FILE: src/hsvih_dp.sv
// datapath: bin matching, row sum and line store memories, result register
// depends on hsvih_pkg
module hsvih_dp #(
    parameter int HUE_BINS  = 17,
    parameter int SV_BINS   = 16,
    parameter int XW        = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hsvih_pkg::cmd_t                    cmd,
    input  logic [XW-1:0]                      col,
    input  logic [hsvih_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [hsvih_pkg::EDGE_BUS_W-1:0]   hue_edges,
    input  logic [hsvih_pkg::EDGE_BUS_W-1:0]   satval_edges,
    output logic                               stall,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hsvih_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast
);
    import hsvih_pkg::*;

    localparam int NUM_CH   = HUE_BINS + 2 * SV_BINS;
    localparam int CHA_W    = $clog2(NUM_CH);
    localparam int LSA_W    = CHA_W + XW;
    localparam int LS_DEPTH = NUM_CH * (2 ** XW);
    localparam int PAD_W    = OUT_TDATA_W - CH_W - COUNT_W;

    // memories
    logic [ROWSUM_W-1:0] rs_mem [NUM_CH];
    logic [COUNT_W-1:0]  ls_mem [LS_DEPTH];

    logic [SAMPLE_W-1:0] hue_reg, sat_reg, val_reg;

    logic [SAMPLE_W-1:0]   sample;
    logic [EDGE_BUS_W-1:0] edges;
    logic [EDGE_W-1:0]     lo_edge, hi_edge;
    logic                  match;
    logic [LSA_W-1:0]      ls_addr;

    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic                s1_match_reg;
    logic                s1_last_reg;
    logic                s1_first_row_reg;
    logic                s1_first_col_reg;
    logic [LSA_W-1:0]    s1_addr_reg;
    logic [ROWSUM_W-1:0] rs_rd_reg;
    logic [COUNT_W-1:0]  ls_rd_reg;

    logic [ROWSUM_W-1:0] rs_new;
    logic [COUNT_W-1:0]  count;
    logic                advance;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;

    // pixel sample holding
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hue_reg <= s_tdata[SAMPLE_W-1:0];
            sat_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            val_reg <= s_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
        end
    end

    // bin test for the channel being issued
    always_comb begin
        case (cmd.kind)
            KIND_HUE: begin
                sample = hue_reg;
                edges  = hue_edges;
            end
            KIND_SAT: begin
                sample = sat_reg;
                edges  = satval_edges;
            end
            KIND_VAL: begin
                sample = val_reg;
                edges  = satval_edges;
            end
            default: begin
                sample = hue_reg;
                edges  = hue_edges;
            end
        endcase
        lo_edge = edge_at(edges, cmd.bin);
        hi_edge = edge_at(edges, cmd.bin + BIN_W'(1));
        match   = (EDGE_W'(sample) >= lo_edge) && (EDGE_W'(sample) < hi_edge);
    end

    assign ls_addr = {cmd.ch[CHA_W-1:0], col};
    assign stall   = out_valid_reg && !m_tready;
    assign advance = s1_valid_reg && !stall;

    // issue stage: command capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (!stall) begin
            s1_valid_reg <= cmd.issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            s1_ch_reg        <= cmd.ch;
            s1_match_reg     <= match;
            s1_last_reg      <= cmd.last;
            s1_first_row_reg <= cmd.first_row;
            s1_first_col_reg <= cmd.first_col;
            s1_addr_reg      <= ls_addr;
        end
    end

    // row sum memory: read on issue, written back when the issue stage advances
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rs_rd_reg <= rs_mem[cmd.ch[CHA_W-1:0]];
        end
        if (advance) begin
            rs_mem[s1_ch_reg[CHA_W-1:0]] <= rs_new;
        end
    end

    // line store: previous row integral per channel and column
    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            ls_rd_reg <= ls_mem[ls_addr];
        end
        if (advance) begin
            ls_mem[s1_addr_reg] <= count;
        end
    end

    // row sum restarts at column zero, first row has nothing above
    always_comb begin
        rs_new = (s1_first_col_reg ? '0 : rs_rd_reg) + ROWSUM_W'(s1_match_reg);
        count  = (s1_first_row_reg ? '0 : ls_rd_reg) + COUNT_W'(rs_new);
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!stall) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_ch_reg    <= s1_ch_reg;
            out_count_reg <= count;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/hsv_integral_histogram.sv
// top level of the hsv integral histogram block
// depends on hsvih_pkg, hsvih_cfg, hsvih_ctrl, hsvih_dp and the assertion macro header
//
//  channel   direction  payload
//  s_*       in         one hsv pixel per request
//  m_*       out        one channel count per request, tlast on the final channel
//  cfg_*     in         register index and write data
//
// each pixel is accepted, then its HUE_BINS + 2*SV_BINS channels are issued one per cycle
// while the result register is not stalled, through the single read port of the line store;
// the first count passes the issue stage registers and the result register. a new pixel is
// taken the cycle after the last channel is issued. a stalled result register holds the whole
// channel sequence. the line store needs no clearing after reset: first-row reads are unused.
`include "hsv_integral_histogram_macros.svh"
module hsv_integral_histogram #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int HUE_BINS   = 17,
    parameter int SV_BINS    = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // hue_sample [7:0], sat_sample [15:8], val_sample [23:16]
    input  logic [hsvih_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // channel [5:0], bin_count [26:6], zero [31:27]
    output logic [hsvih_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hsvih_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsvih_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hsvih_pkg::*;

    localparam int NUM_CH = HUE_BINS + 2 * SV_BINS;
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CH - 1);

    logic [SIZE_CFG_W-1:0] image_width;
    logic [SIZE_CFG_W-1:0] image_height;
    logic [EDGE_BUS_W-1:0] hue_edges;
    logic [EDGE_BUS_W-1:0] satval_edges;
    cmd_t                  cmd;
    logic [XW-1:0]         col;
    logic                  stall;
    logic [CH_W-1:0]       m_ch;

    // configuration registers
    hsvih_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .image_width  (image_width),
        .image_height (image_height),
        .hue_edges    (hue_edges),
        .satval_edges (satval_edges)
    );

    // sequencer
    hsvih_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .HUE_BINS   (HUE_BINS),
        .SV_BINS    (SV_BINS),
        .XW         (XW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .stall        (stall),
        .image_width  (image_width),
        .image_height (image_height),
        .cmd          (cmd),
        .col          (col)
    );

    // datapath
    hsvih_dp #(
        .HUE_BINS  (HUE_BINS),
        .SV_BINS   (SV_BINS),
        .XW        (XW)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .col          (col),
        .s_tdata      (s_tdata),
        .hue_edges    (hue_edges),
        .satval_edges (satval_edges),
        .stall        (stall),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    assign m_ch = m_tdata[CH_W-1:0];

    // checks
    `HSVIH_NEVER(a_no_request_while_issuing, cmd.issue && s_tready, "pixel taken mid-sequence")
    `HSVIH_NEVER(a_no_issue_on_stall, m_tvalid && !m_tready && cmd.issue, "issue during stall")
    `HSVIH_ASSERT(a_idle_after_last, (cmd.issue && cmd.last) |=> s_tready, "not idle after last")
    `HSVIH_NEVER(a_tlast_channel, m_tvalid && m_tlast && m_ch != LAST_CH, "tlast on wrong channel")

endmodule
